>>> src/spc_pkg.sv
// Package for the seven-bit pack codec.
// Holds the job type passed from the front end to the back end and shared constants.
// No dependencies.
package spc_pkg;

    localparam int SPC_QUEUE_DEPTH = 4;

    localparam logic [7:0] SPC_CODE_MARK = 8'h80;
    localparam logic [7:0] SPC_FILL_BYTE = 8'h80;

    typedef enum logic {
        DIR_ENCODE = 1'b0,
        DIR_DECODE = 1'b1
    } t_direction;

    // One job is every result that a single accepted item causes.
    // Result 0 is byte0, result 1 is byte1, and any further result is a fill byte.
    typedef struct packed {
        logic [7:0] byte0;
        logic       bad0;
        logic [7:0] byte1;
        logic       bad1;
        logic [2:0] last_idx;
        logic       eom;
    } t_job;

    typedef struct packed {
        logic push;
        t_job job;
    } t_job_wr;

endpackage

>>> src/spc_front.sv
// Front end of the seven-bit pack codec: accepts items, tracks group state
// and turns each item into at most one job descriptor. Depends on spc_pkg.
module spc_front
    import spc_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_valid,
    input  logic       i_cfg_data,
    input  logic       i_accept,
    input  logic [7:0] i_in_byte,
    input  logic       i_end_of_message,
    output t_job_wr    o_wr
);

    t_direction  r_direction;
    logic [6:0]  r_residual;
    logic [2:0]  r_group_pos;
    logic        r_discarding;

    logic [6:0]  n_residual;
    logic [2:0]  n_group_pos;
    logic        n_discarding;

    logic [2:0]  p;
    logic [7:0]  enc_mask;
    logic [6:0]  enc_keep;
    logic [13:0] enc_hi;
    logic [6:0]  enc_code;
    logic [13:0] enc_tail;
    logic [2:0]  k;
    logic [2:0]  k_next;
    logic [6:0]  c;
    logic [14:0] dec_hi;
    logic [7:0]  dec_data;
    logic [7:0]  dec_mask;
    t_job        job;
    logic        push;

    always_comb begin
        p         = (r_group_pos > 3'd6) ? 3'd0 : r_group_pos;
        enc_mask  = (8'd1 << ({1'b0, p} + 4'd1)) - 8'd1;
        enc_keep  = i_in_byte[6:0] & enc_mask[6:0];
        enc_hi    = {7'd0, r_residual} << (3'd7 - p);
        enc_code  = enc_hi[6:0] | 7'(i_in_byte >> ({1'b0, p} + 4'd1));
        enc_tail  = {7'd0, enc_keep} << (3'd6 - p);

        k         = r_group_pos;
        k_next    = k + 3'd1;
        c         = i_in_byte[6:0];
        dec_hi    = {8'd0, r_residual} << k;
        dec_data  = dec_hi[7:0] | {1'b0, c >> (3'd7 - k)};
        dec_mask  = (8'd1 << (3'd7 - k)) - 8'd1;

        n_residual   = r_residual;
        n_group_pos  = r_group_pos;
        n_discarding = r_discarding;
        push         = 1'b0;
        job.byte0    = 8'd0;
        job.bad0     = 1'b0;
        job.byte1    = 8'd0;
        job.bad1     = 1'b0;
        job.last_idx = 3'd0;
        job.eom      = i_end_of_message;

        if (r_discarding) begin
            // drop everything up to and including the end of message
            if (i_end_of_message) begin
                n_discarding = 1'b0;
                n_residual   = 7'd0;
                n_group_pos  = 3'd0;
            end
        end else if (r_direction == DIR_ENCODE) begin
            push      = 1'b1;
            job.byte0 = SPC_CODE_MARK | {1'b0, enc_code};
            job.byte1 = SPC_CODE_MARK | {1'b0, enc_tail[6:0]};
            if (i_end_of_message) begin
                // pad the group with zero bytes up to eight code bytes
                job.last_idx = 3'd7 - p;
                n_residual   = 7'd0;
                n_group_pos  = 3'd0;
            end else if (p == 3'd6) begin
                job.last_idx = 3'd1;
                n_residual   = 7'd0;
                n_group_pos  = 3'd0;
            end else begin
                n_residual   = enc_keep;
                n_group_pos  = p + 3'd1;
            end
        end else begin
            if (k == 3'd0) begin
                n_residual  = c;
                n_group_pos = 3'd1;
                if (i_end_of_message) begin
                    push     = 1'b1;
                    job.bad0 = 1'b1;
                end
            end else if (!i_in_byte[7]) begin
                push         = 1'b1;
                job.bad0     = 1'b1;
                n_residual   = 7'd0;
                n_group_pos  = 3'd0;
                n_discarding = !i_end_of_message;
            end else begin
                push        = 1'b1;
                job.byte0   = dec_data;
                n_group_pos = k_next;
                n_residual  = (k_next == 3'd0) ? 7'd0 : (c & dec_mask[6:0]);
                if (i_end_of_message && k_next != 3'd0) begin
                    // incomplete final group
                    job.bad1     = 1'b1;
                    job.last_idx = 3'd1;
                end
            end
            if (i_end_of_message) begin
                n_residual  = 7'd0;
                n_group_pos = 3'd0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_direction  <= DIR_ENCODE;
            r_residual   <= 7'd0;
            r_group_pos  <= 3'd0;
            r_discarding <= 1'b0;
        end else if (i_cfg_valid) begin
            r_direction  <= t_direction'(i_cfg_data);
            r_residual   <= 7'd0;
            r_group_pos  <= 3'd0;
            r_discarding <= 1'b0;
        end else if (i_accept) begin
            r_residual   <= n_residual;
            r_group_pos  <= n_group_pos;
            r_discarding <= n_discarding;
        end
    end

    assign o_wr.push = i_accept && push && !i_cfg_valid;
    assign o_wr.job  = job;

`ifndef SYNTHESIS
    a_enc_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_direction == DIR_ENCODE |-> r_group_pos != 3'd7)
        else $error("encoder group position out of range");
    a_discard_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_discarding |-> (r_group_pos == 3'd0 && r_residual == 7'd0))
        else $error("group state not cleared while dropping");
    a_discard_nojob: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_discarding |-> !o_wr.push)
        else $error("job issued while dropping");
`endif

endmodule

>>> src/spc_queue.sv
// Short job queue between the front end and the back end of the codec.
// Register array with read and write pointers. Depends on spc_pkg.
module spc_queue
    import spc_pkg::*;
#(
    parameter int DEPTH = SPC_QUEUE_DEPTH
)
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_job_wr i_wr,
    input  logic    i_deq,
    output logic    o_full,
    output logic    o_valid,
    output t_job    o_head
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    t_job            r_mem [DEPTH];
    logic [PW-1:0]   r_wptr;
    logic [PW-1:0]   r_rptr;
    logic [CW-1:0]   r_count;
    logic            do_wr;
    logic            do_rd;

    assign o_full  = (r_count == FULL_CNT);
    assign o_valid = (r_count != '0);
    assign o_head  = r_mem[r_rptr];
    assign do_wr   = i_wr.push && !o_full;
    assign do_rd   = i_deq && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_wr) begin
            r_mem[r_wptr] <= i_wr.job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (do_wr) begin
                r_wptr <= (r_wptr == LAST_PTR) ? '0 : r_wptr + PW'(1);
            end
            if (do_rd) begin
                r_rptr <= (r_rptr == LAST_PTR) ? '0 : r_rptr + PW'(1);
            end
            if (do_wr && !do_rd) begin
                r_count <= r_count + CW'(1);
            end else if (do_rd && !do_wr) begin
                r_count <= r_count - CW'(1);
            end
        end
    end

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= FULL_CNT)
        else $error("queue count beyond depth");
    a_push_not_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_wr.push |-> !o_full)
        else $error("job pushed into a full queue");
    a_deq_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_deq |-> o_valid)
        else $error("dequeue from an empty queue");
`endif

endmodule

>>> src/spc_back.sv
// Back end of the seven-bit pack codec: expands each job into its result
// items and holds the oldest one in the output register. Depends on spc_pkg.
module spc_back
    import spc_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_head_valid,
    input  t_job       i_head,
    input  logic       i_pop,
    output logic       o_deq,
    output logic       o_empty,
    output logic [7:0] o_out_byte,
    output logic       o_last_of_run,
    output logic       o_message_done,
    output logic       o_bad_code
);

    logic [2:0] r_idx;
    logic       r_out_valid;
    logic [7:0] r_out_byte;
    logic       r_last;
    logic       r_done;
    logic       r_bad;

    logic       load;
    logic       is_last;
    logic [7:0] sel_byte;
    logic       sel_bad;

    assign load    = i_head_valid && (!r_out_valid || i_pop);
    assign is_last = (r_idx == i_head.last_idx);
    assign o_deq   = load && is_last;

    always_comb begin
        case (r_idx)
            3'd0: begin
                sel_byte = i_head.byte0;
                sel_bad  = i_head.bad0;
            end
            3'd1: begin
                sel_byte = i_head.byte1;
                sel_bad  = i_head.bad1;
            end
            default: begin
                sel_byte = SPC_FILL_BYTE;
                sel_bad  = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx       <= 3'd0;
            r_out_valid <= 1'b0;
        end else begin
            if (load) begin
                r_out_valid <= 1'b1;
                r_idx       <= is_last ? 3'd0 : r_idx + 3'd1;
            end else if (i_pop) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_out_byte <= sel_byte;
            r_bad      <= sel_bad;
            r_last     <= is_last;
            r_done     <= is_last && i_head.eom;
        end
    end

    assign o_empty        = !r_out_valid;
    assign o_out_byte     = r_out_byte;
    assign o_last_of_run  = r_last;
    assign o_message_done = r_done;
    assign o_bad_code     = r_bad;

`ifndef SYNTHESIS
    a_mid_job_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_idx != 3'd0 |-> (i_head_valid && r_idx <= i_head.last_idx))
        else $error("result index without a matching job");
    a_done_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_done |-> r_last)
        else $error("message end on a result that is not last of its run");
    a_bad_is_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_bad |-> r_out_byte == 8'd0)
        else $error("error result carries a nonzero byte");
`endif

endmodule

>>> src/seven_bit_pack_codec_unit.sv
// Top level of the seven-bit pack codec: front end, job queue and back end.
// Depends on spc_pkg, spc_front, spc_queue and spc_back.
//
// The codec accepts one byte per cycle while full is low. The front end updates
// the group state in the cycle the item is accepted and hands a job to a queue
// of QUEUE_DEPTH entries; the back end sends one result per cycle out of its
// output register while pop is high and a job waits. An item has n results
// (n is 2 for the seventh data byte of an encode group, 8 - position for an
// encode end of message, up to 2 for decode), and full rises once the queue
// has filled behind a busy back end. Items with no result do not reach the back
// end. The first result of an item goes through the queue and then the output
// register. Configuration writes are always ready and clear the group state.
module seven_bit_pack_codec_unit
    import spc_pkg::*;
#(
    parameter int QUEUE_DEPTH = SPC_QUEUE_DEPTH
)
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic       i_cfg_data,
    input  logic       push,
    output logic       full,
    input  logic [7:0] i_in_byte,
    input  logic       i_end_of_message,
    output logic       empty,
    input  logic       pop,
    output logic [7:0] o_out_byte,
    output logic       o_last_of_run,
    output logic       o_message_done,
    output logic       o_bad_code
);

    t_job_wr wr;
    t_job    head;
    logic    head_valid;
    logic    deq;
    logic    q_full;
    logic    accept;

    assign o_cfg_ready = 1'b1;
    assign full        = q_full;
    assign accept      = push && !q_full;

    spc_front u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_valid      (i_cfg_valid),
        .i_cfg_data       (i_cfg_data),
        .i_accept         (accept),
        .i_in_byte        (i_in_byte),
        .i_end_of_message (i_end_of_message),
        .o_wr             (wr)
    );

    spc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (wr),
        .i_deq   (deq),
        .o_full  (q_full),
        .o_valid (head_valid),
        .o_head  (head)
    );

    spc_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_head_valid   (head_valid),
        .i_head         (head),
        .i_pop          (pop),
        .o_deq          (deq),
        .o_empty        (empty),
        .o_out_byte     (o_out_byte),
        .o_last_of_run  (o_last_of_run),
        .o_message_done (o_message_done),
        .o_bad_code     (o_bad_code)
    );

endmodule

>>> sim/tb_seven_bit_pack_codec_unit.sv
// Testbench for seven_bit_pack_codec_unit: drives byte items in both directions and
// checks every result against an in-bench model of the 7-to-8 packing codec.
// Depends on spc_pkg and the seven_bit_pack_codec_unit RTL.
module tb_seven_bit_pack_codec_unit;
    import spc_pkg::*;

    typedef struct {
        logic [7:0] data;
        logic       eom;
    } t_in_item;

    typedef struct {
        logic [7:0] out_byte;
        logic       last;
        logic       done;
        logic       bad;
    } t_out_item;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_cfg_valid = 1'b0;
    logic       i_cfg_data = 1'b0;
    logic       push = 1'b0;
    logic [7:0] i_in_byte = 8'h00;
    logic       i_end_of_message = 1'b0;
    logic       pop = 1'b0;
    logic       o_cfg_ready;
    logic       full;
    logic       empty;
    logic [7:0] o_out_byte;
    logic       o_last_of_run;
    logic       o_message_done;
    logic       o_bad_code;

    t_in_item    byte_q[$];
    t_out_item   exp_results[$];
    t_out_item   step_res[$];
    int unsigned send_idle_pct = 0;
    int unsigned pop_stall_pct = 0;
    int unsigned mismatch_cnt = 0;
    int unsigned items_queued = 0;

    // Model state of the codec
    t_direction  cur_dir = DIR_ENCODE;
    logic [6:0]  held_bits = '0;
    logic [2:0]  grp_pos = '0;
    logic        dropping = 1'b0;

    seven_bit_pack_codec_unit i_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_data       (i_cfg_data),
        .push             (push),
        .full             (full),
        .i_in_byte        (i_in_byte),
        .i_end_of_message (i_end_of_message),
        .empty            (empty),
        .pop              (pop),
        .o_out_byte       (o_out_byte),
        .o_last_of_run    (o_last_of_run),
        .o_message_done   (o_message_done),
        .o_bad_code       (o_bad_code)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    function automatic void clear_group();
        held_bits = '0;
        grp_pos = '0;
        dropping = 1'b0;
    endfunction

    function automatic void emit_result(logic [7:0] b, logic bad);
        t_out_item r;
        r.out_byte = b;
        r.last = 1'b0;
        r.done = 1'b0;
        r.bad = bad;
        step_res.push_back(r);
    endfunction

    function automatic void encode_one(logic [7:0] b);
        int unsigned p, hb, bb, code;
        p = grp_pos;
        hb = held_bits;
        bb = b;
        if (p > 6) p = 0;
        code = ((hb << (7 - p)) | (bb >> (p + 1))) & 'h7F;
        emit_result(SPC_CODE_MARK | 8'(code), 1'b0);
        held_bits = 7'(bb & ((1 << (p + 1)) - 1));
        p++;
        // seventh data byte flushes the held bits as an extra code byte
        if (p == 7) begin
            emit_result(SPC_CODE_MARK | {1'b0, held_bits}, 1'b0);
            held_bits = '0;
            p = 0;
        end
        grp_pos = 3'(p);
    endfunction

    function automatic void pack_predict(logic [7:0] b, logic eom);
        int unsigned k, hb, c, data;
        t_out_item r;
        step_res.delete();
        if (dropping) begin
            if (eom) clear_group();
            return;
        end
        if (cur_dir == DIR_ENCODE) begin
            encode_one(b);
            if (eom) begin
                // pad the group with zero bytes
                while (grp_pos != 0) encode_one(8'h00);
                clear_group();
            end
        end else begin
            k = grp_pos;
            hb = held_bits;
            c = b[6:0];
            if (k == 0) begin
                held_bits = b[6:0];
                grp_pos = 3'd1;
            end else if (!b[7]) begin
                emit_result(8'h00, 1'b1);
                clear_group();
                dropping = !eom;
            end else begin
                data = ((hb << k) | (c >> (7 - k))) & 'hFF;
                emit_result(8'(data), 1'b0);
                held_bits = 7'(c & ((1 << (7 - k)) - 1));
                grp_pos = 3'(k + 1);
                if (grp_pos == 0) held_bits = '0;
            end
            if (eom) begin
                if (grp_pos != 0) emit_result(8'h00, 1'b1);
                clear_group();
            end
        end
        if (step_res.size() != 0) begin
            r = step_res.pop_back();
            r.last = 1'b1;
            r.done = eom;
            step_res.push_back(r);
        end
        foreach (step_res[i]) exp_results.push_back(step_res[i]);
    endfunction

    // Sender: hold the item until accepted, then advance
    always @(posedge i_clk) begin
        t_in_item nxt;
        if (!i_rst_n) begin
            push <= 1'b0;
        end else begin
            if (push && !full) pack_predict(i_in_byte, i_end_of_message);
            if (!push || !full) begin
                if (byte_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    nxt = byte_q.pop_front();
                    push <= 1'b1;
                    i_in_byte <= nxt.data;
                    i_end_of_message <= nxt.eom;
                end else begin
                    push <= 1'b0;
                end
            end
        end
    end

    // Receiver: check each accepted result against the oldest expectation
    always @(posedge i_clk) begin
        t_out_item e;
        if (!i_rst_n) begin
            pop <= 1'b0;
        end else begin
            if (pop && !empty) begin
                if (exp_results.size() == 0) begin
                    $error("result with nothing expected: out_byte %h", o_out_byte);
                    mismatch_cnt++;
                end else begin
                    e = exp_results.pop_front();
                    if (o_out_byte !== e.out_byte) begin
                        $error("out_byte: expected %h, got %h", e.out_byte, o_out_byte);
                        mismatch_cnt++;
                    end
                    if (o_last_of_run !== e.last) begin
                        $error("last_of_run: expected %b, got %b", e.last, o_last_of_run);
                        mismatch_cnt++;
                    end
                    if (o_message_done !== e.done) begin
                        $error("message_done: expected %b, got %b", e.done, o_message_done);
                        mismatch_cnt++;
                    end
                    if (o_bad_code !== e.bad) begin
                        $error("bad_code: expected %b, got %b", e.bad, o_bad_code);
                        mismatch_cnt++;
                    end
                end
            end
            pop <= ($urandom_range(99) >= pop_stall_pct);
        end
    end

    task automatic add_item(logic [7:0] data, logic eom);
        t_in_item it;
        it.data = data;
        it.eom = eom;
        byte_q.push_back(it);
        items_queued++;
    endtask

    task automatic wait_drained();
        do @(posedge i_clk); while (byte_q.size() != 0 || push || exp_results.size() != 0);
    endtask

    task automatic write_direction(t_direction d);
        wait_drained();
        // let a trailing no-result item clear the front end
        repeat (8) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data <= d;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        cur_dir = d;
        clear_group();
    endtask

    task automatic add_encode_msg(int len, logic with_eom);
        for (int i = 0; i < len; i++) add_item(8'($urandom_range(255)), with_eom && i == len - 1);
    endtask

    task automatic add_decode_msg();
        int kind, len, bad_at;
        logic [7:0] b;
        kind = $urandom_range(99);
        len = 8 * $urandom_range(1, 2);
        bad_at = -1;
        if (kind < 15) begin
            len = $urandom_range(1, 15);
        end else if (kind < 30) begin
            bad_at = 8 * $urandom_range(0, len / 8 - 1) + $urandom_range(1, 7);
        end else if (kind < 38) begin
            len = $urandom_range(1, 12);
        end
        for (int i = 0; i < len; i++) begin
            b = 8'($urandom_range(255));
            // keep the mark on non-leading bytes except for noise messages
            if (i % 8 != 0 && (kind < 30 || kind >= 38)) b[7] = 1'b1;
            if (i == bad_at) b[7] = 1'b0;
            add_item(b, i == len - 1);
        end
    endtask

    initial begin
        int unsigned idle_tab[4][2];
        int unsigned phase_end;
        t_direction d;
        idle_tab = '{'{0, 0}, '{50, 0}, '{0, 50}, '{36, 36}};
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Encode: full group without padding, then a lone byte padded to eight
        add_item(8'h00, 1'b0);
        add_item(8'hFF, 1'b0);
        add_item(8'h80, 1'b0);
        add_item(8'h7F, 1'b0);
        add_item(8'h55, 1'b0);
        add_item(8'hAA, 1'b0);
        add_item(8'h01, 1'b1);
        add_item(8'hFF, 1'b1);

        write_direction(DIR_DECODE);
        // full group of all-ones codes
        for (int i = 0; i < 8; i++) add_item(8'hFF, i == 7);
        // leading byte without mark, then a short final group
        add_item(8'h00, 1'b0);
        add_item(8'h80, 1'b1);
        // missing mark mid-message: drop the rest up to end of message
        add_item(8'h81, 1'b0);
        add_item(8'h05, 1'b0);
        add_item(8'h90, 1'b0);
        add_item(8'hFF, 1'b1);
        // missing mark on the final byte
        add_item(8'h80, 1'b0);
        add_item(8'h01, 1'b1);
        // end of message on the leading byte
        add_item(8'h7F, 1'b1);

        for (int ph = 0; ph < 8; ph++) begin
            d = (ph % 2 == 0) ? DIR_ENCODE : DIR_DECODE;
            write_direction(d);
            send_idle_pct = idle_tab[ph / 2][0];
            pop_stall_pct = idle_tab[ph / 2][1];
            phase_end = items_queued + 4;
            while (items_queued < phase_end) begin
                if (d == DIR_ENCODE) begin
                    add_encode_msg($urandom_range(1, 16), 1'b1);
                end else begin
                    add_decode_msg();
                end
                // in decode phases, hold the sender until the pipe is empty while the phase is unfinished
                if (items_queued < phase_end && ph % 2 == 1 && items_queued + 10 > phase_end)
                    wait_drained();
            end
            if (ph == 0) wait_drained();
            // leave a group open for the next write to clear
            if (d == DIR_ENCODE) begin
                add_encode_msg($urandom_range(1, 5), 1'b0);
            end else begin
                for (int i = $urandom_range(1, 5); i > 0; i--)
                    add_item(8'h80 | 8'($urandom_range(127)), 1'b0);
            end
        end
        write_direction(DIR_ENCODE);
        add_encode_msg(6, 1'b1);

        wait_drained();
        repeat (20) @(posedge i_clk);
        if (exp_results.size() != 0) begin
            $error("%0d expected results never arrived", exp_results.size());
            mismatch_cnt++;
        end
        if (mismatch_cnt == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("Mismatches found");
        $finish;
    end

endmodule

>>> files.f
src/spc_pkg.sv
src/spc_front.sv
src/spc_queue.sv
src/spc_back.sv
src/seven_bit_pack_codec_unit.sv
sim/tb_seven_bit_pack_codec_unit.sv
